// File: src/p3dp_pkg.sv
`default_nettype none
package p3dp_pkg;

    // defaults of the top level parameters
    localparam int SCREEN_WIDTH_DEF  = 1920;
    localparam int SCREEN_HEIGHT_DEF = 1080;
    localparam int ANGLE_BITS_DEF    = 10;

    // register indexes
    localparam logic [2:0] REG_ZOOM       = 3'd0;
    localparam logic [2:0] REG_Z_ZOOM     = 3'd1;
    localparam logic [2:0] REG_ANGLES     = 3'd2;
    localparam logic [2:0] REG_ISO_MODE   = 3'd3;
    localparam logic [2:0] REG_MAP_WIDTH  = 3'd4;
    localparam logic [2:0] REG_MAP_HEIGHT = 3'd5;
    localparam logic [2:0] REG_SHIFT_X    = 3'd6;
    localparam logic [2:0] REG_SHIFT_Y    = 3'd7;

    // coordinate width, product width, Q1.14 trig width
    localparam int CW  = 36;
    localparam int PW  = 52;
    localparam int TW  = 16;
    localparam int QF  = 14;

    localparam logic signed [TW-1:0] ISO_COS = 16'sd11415;
    localparam logic signed [TW-1:0] ISO_SIN = 16'sd11753;

    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [TW-1:0] trig_t;

    // quarter wave sine of k / 2^ab turns in Q1.14, Taylor series in Q30
    function automatic logic [QF:0] quarter_sin(input int unsigned k, input int ab);
        logic [63:0] x;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] rnd;
        x = (64'(k) * TWO_PI_Q30) >> ab;
        term = x;
        sum = $signed(x);
        for (int n = 1; n <= 6; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (n)
                1: term = term / 6;
                2: term = term / 20;
                3: term = term / 42;
                4: term = term / 72;
                5: term = term / 110;
                default: term = term / 156;
            endcase
            if (n % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = '0;
        rnd = ($unsigned(sum) + 64'd32768) >> 16;
        return rnd[QF:0];
    endfunction

    // signed product at full width
    function automatic prod_t mul_q(input coord_t a, input trig_t c);
        prod_t ae;
        prod_t ce;
        ae = PW'(a);
        ce = PW'(c);
        return ae * ce;
    endfunction

    // divide by 2^14, truncating toward zero
    function automatic coord_t trunc_q(input prod_t v);
        prod_t b;
        prod_t s;
        b = v[PW-1] ? prod_t'((1 << QF) - 1) : '0;
        s = (v + b) >>> QF;
        return s[CW-1:0];
    endfunction

    // clamp to 32-bit signed
    function automatic logic signed [31:0] sat32(input coord_t v);
        coord_t hi;
        coord_t lo;
        hi = CW'(33'sh0_7FFF_FFFF);
        lo = -hi - coord_t'(1);
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage
`default_nettype wire

// File: src/point_3d_projection_top.sv
// Channel   Direction  Signals                              Handshake
// -------   ---------  -----------------------------------  ------------------------
// point     in         point_x, point_y, point_z            start & !busy
// result    out        screen_x, screen_y, depth_z          done, one cycle, no stall
// config    in         cfg_addr, cfg_data                   cfg_wr_en
//
// A point enters every cycle; its result strobes done after twelve register
// stages (input register, scale, three rotations of product and sum stages,
// iso sum, iso product, iso select, offset and clamp).
// busy stays low.
// rst_n clears the valid bits and loads the register defaults.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module point_3d_projection_top
    import p3dp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output      logic               busy,
    input  wire logic [11:0]        point_x,
    input  wire logic [11:0]        point_y,
    input  wire logic signed [15:0] point_z,
    output      logic               done,
    output      logic signed [31:0] screen_x,
    output      logic signed [31:0] screen_y,
    output      logic signed [31:0] depth_z,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [29:0]        cfg_data
);

    localparam int LAT  = 12;
    localparam int QN   = 1 << (ANGLE_BITS - 2);
    localparam int OFFW = 22;
    localparam int SCR_X_OFF = SCREEN_WIDTH / 8;
    localparam int AW3  = 3 * ANGLE_BITS;

    logic accept;
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // configuration registers
    logic [7:0]        zoom_reg;
    logic signed [13:0] z_zoom_reg;
    logic [29:0]       angles_reg;
    logic              iso_reg;
    logic [12:0]       map_w_reg;
    logic [12:0]       map_h_reg;
    logic signed [15:0] shift_x_reg;
    logic signed [15:0] shift_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg    <= 8'd20;
            z_zoom_reg  <= 14'sd20;
            angles_reg  <= '0;
            iso_reg     <= 1'b1;
            map_w_reg   <= '0;
            map_h_reg   <= '0;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_ZOOM:       zoom_reg    <= cfg_data[7:0];
                REG_Z_ZOOM:     z_zoom_reg  <= cfg_data[13:0];
                REG_ANGLES:     angles_reg  <= cfg_data;
                REG_ISO_MODE:   iso_reg     <= cfg_data[0];
                REG_MAP_WIDTH:  map_w_reg   <= cfg_data[12:0];
                REG_MAP_HEIGHT: map_h_reg   <= cfg_data[12:0];
                REG_SHIFT_X:    shift_x_reg <= cfg_data[15:0];
                REG_SHIFT_Y:    shift_y_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // derived offsets, refreshed every cycle from the registers
    logic [OFFW-1:0] off_x_reg;
    logic [OFFW-1:0] off_y_reg;
    logic [OFFW-1:0] scr_y_reg;
    logic [OFFW-1:0] mw_prod;
    logic [OFFW-1:0] mh_prod;

    assign mw_prod = OFFW'(map_w_reg) * OFFW'(zoom_reg);
    assign mh_prod = OFFW'(map_h_reg) * OFFW'(zoom_reg);

    always_ff @(posedge clk)
    begin
        off_x_reg <= mw_prod >> 3;
        off_y_reg <= mh_prod >> 3;
        scr_y_reg <= (OFFW'(SCREEN_HEIGHT) + mh_prod) >> 3;
    end

    // quarter wave sine table
    logic [QF:0] qsin [QN+1];
    for (genvar k = 0; k <= QN; k++)
    begin : g_qsin
        assign qsin[k] = quarter_sin(k, ANGLE_BITS);
    end

    // look up sin (0..2) and cos (3..5) of the three angles
    logic [AW3+29:0] ang_wide;
    trig_t sc_reg [6];
    assign ang_wide = {(AW3)'(0), angles_reg};

    for (genvar j = 0; j < 6; j++)
    begin : g_trig
        logic [ANGLE_BITS-1:0] a;
        logic [ANGLE_BITS-1:0] base;
        logic [1:0]            quad;
        logic [ANGLE_BITS-1:0] r;
        logic [ANGLE_BITS-2:0] kidx;
        trig_t                 mag;

        assign base = ang_wide[(j % 3) * ANGLE_BITS +: ANGLE_BITS];
        assign a    = (j < 3) ? base : base + ANGLE_BITS'(QN);
        assign quad = a[ANGLE_BITS-1:ANGLE_BITS-2];
        assign r    = {2'b00, a[ANGLE_BITS-3:0]};
        assign kidx = quad[0] ? (ANGLE_BITS-1)'(ANGLE_BITS'(QN) - r)
                              : r[ANGLE_BITS-2:0];
        assign mag  = TW'(qsin[kidx]);

        always_ff @(posedge clk)
        begin
            sc_reg[j] <= quad[1] ? -mag : mag;
        end
    end

    // valid bits
    logic [LAT-1:0] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[LAT-2:0], accept};
    end
    assign done = v_reg[LAT-1];

    // stage 0: capture the word
    logic [11:0]        px0_reg;
    logic [11:0]        py0_reg;
    logic signed [15:0] pz0_reg;
    always_ff @(posedge clk)
    begin
        px0_reg <= point_x;
        py0_reg <= point_y;
        pz0_reg <= point_z;
    end

    // stage 1: scale and center
    coord_t x1_reg, y1_reg, z1_reg;
    always_ff @(posedge clk)
    begin
        x1_reg <= CW'(px0_reg) * CW'(zoom_reg) - CW'(off_x_reg);
        y1_reg <= CW'(py0_reg) * CW'(zoom_reg) - CW'(off_y_reg);
        z1_reg <= CW'(pz0_reg) * CW'(z_zoom_reg);
    end

    // stages 2, 3: rotate about x
    prod_t  p2a_reg, p2b_reg, p2c_reg, p2d_reg;
    coord_t x2_reg;
    coord_t x3_reg, y3_reg, z3_reg;
    always_ff @(posedge clk)
    begin
        p2a_reg <= mul_q(y1_reg, sc_reg[3]);
        p2b_reg <= mul_q(z1_reg, sc_reg[0]);
        p2c_reg <= mul_q(y1_reg, sc_reg[0]);
        p2d_reg <= mul_q(z1_reg, sc_reg[3]);
        x2_reg  <= x1_reg;
        y3_reg  <= trunc_q(p2a_reg + p2b_reg);
        z3_reg  <= trunc_q(p2d_reg - p2c_reg);
        x3_reg  <= x2_reg;
    end

    // stages 4, 5: rotate about y
    prod_t  p4a_reg, p4b_reg, p4c_reg, p4d_reg;
    coord_t y4_reg;
    coord_t x5_reg, y5_reg, z5_reg;
    always_ff @(posedge clk)
    begin
        p4a_reg <= mul_q(x3_reg, sc_reg[4]);
        p4b_reg <= mul_q(z3_reg, sc_reg[1]);
        p4c_reg <= mul_q(x3_reg, sc_reg[1]);
        p4d_reg <= mul_q(z3_reg, sc_reg[4]);
        y4_reg  <= y3_reg;
        x5_reg  <= trunc_q(p4a_reg + p4b_reg);
        z5_reg  <= trunc_q(p4d_reg - p4c_reg);
        y5_reg  <= y4_reg;
    end

    // stages 6, 7: rotate about z
    prod_t  p6a_reg, p6b_reg, p6c_reg, p6d_reg;
    coord_t z6_reg;
    coord_t x7_reg, y7_reg, z7_reg;
    always_ff @(posedge clk)
    begin
        p6a_reg <= mul_q(x5_reg, sc_reg[5]);
        p6b_reg <= mul_q(y5_reg, sc_reg[2]);
        p6c_reg <= mul_q(x5_reg, sc_reg[2]);
        p6d_reg <= mul_q(y5_reg, sc_reg[5]);
        z6_reg  <= z5_reg;
        x7_reg  <= trunc_q(p6a_reg - p6b_reg);
        y7_reg  <= trunc_q(p6c_reg + p6d_reg);
        z7_reg  <= z6_reg;
    end

    // stages 8 to 10: isometric projection, both terms from the old x and y
    coord_t d8_reg, s8_reg, x8_reg, y8_reg, z8_reg;
    prod_t  pd9_reg, ps9_reg;
    coord_t x9_reg, y9_reg, z9_reg;
    coord_t x10_reg, y10_reg, z10_reg;
    always_ff @(posedge clk)
    begin
        d8_reg  <= x7_reg - y7_reg;
        s8_reg  <= x7_reg + y7_reg;
        x8_reg  <= x7_reg;
        y8_reg  <= y7_reg;
        z8_reg  <= z7_reg;
        pd9_reg <= mul_q(d8_reg, ISO_COS);
        ps9_reg <= mul_q(s8_reg, ISO_SIN);
        x9_reg  <= x8_reg;
        y9_reg  <= y8_reg;
        z9_reg  <= z8_reg;
        x10_reg <= iso_reg ? trunc_q(pd9_reg) : x9_reg;
        y10_reg <= iso_reg ? trunc_q(ps9_reg) - z9_reg : y9_reg;
        z10_reg <= z9_reg;
    end

    // stage 11: screen offset and clamp
    always_ff @(posedge clk)
    begin
        screen_x <= sat32(x10_reg + CW'(SCR_X_OFF) + CW'(shift_x_reg));
        screen_y <= sat32(y10_reg + CW'(scr_y_reg) + CW'(shift_y_reg));
        depth_z  <= sat32(z10_reg);
    end

    // checks
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result strobe without a matching accepted word");
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("accepted word produced no result");
    a_cos0: assert property (@(posedge clk) disable iff (!rst_n)
        (angles_reg == '0) |=> (sc_reg[3] == trig_t'(1 << QF) && sc_reg[0] == '0))
        else $error("trig lookup wrong at angle zero");

endmodule
`default_nettype wire

// File: tb/tb_point_3d_projection_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_point_3d_projection_top;
    import p3dp_pkg::*;

    localparam int AB       = ANGLE_BITS_DEF;
    localparam int ANG_N    = 1 << AB;
    localparam int LATENCY  = 12;
    localparam int WD_LIMIT = 5000;

    typedef struct {
        logic [11:0]        px;
        logic [11:0]        py;
        logic signed [15:0] pz;
    } point_t;

    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] dz;
    } screen_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [11:0]        point_x;
    logic [11:0]        point_y;
    logic signed [15:0] point_z;
    logic               done;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth_z;
    logic               cfg_wr_en;
    logic [2:0]         cfg_addr;
    logic [29:0]        cfg_data;

    point_t  pending_points[$];
    screen_t expected_screen[$];
    int      sine_lut[ANG_N];
    int      send_idle_pct;
    int      n_points;
    int      n_results;
    int      n_errors;
    int      quiet_cycles;

    // shadow copy of the configuration registers
    logic [7:0]         zoom_r;
    logic signed [13:0] z_zoom_r;
    logic [29:0]        angles_r;
    logic               iso_r;
    logic [12:0]        map_w_r;
    logic [12:0]        map_h_r;
    logic signed [15:0] shift_x_r;
    logic signed [15:0] shift_y_r;

    point_3d_projection_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .done      (done),
        .screen_x  (screen_x),
        .screen_y  (screen_y),
        .depth_z   (depth_z),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sine of k / ANG_N turns over the first quarter, Q1.14, Taylor series in Q30
    function automatic int quarter_wave(input longint unsigned k);
        longint unsigned x;
        longint unsigned term;
        longint          acc;
        x = (k * 64'd6746518852) >> AB;
        term = x;
        acc = longint'(x);
        for (int n = 1; n <= 6; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        return int'((longint'(acc) + 32768) >>> 16);
    endfunction

    function automatic longint q14(input longint v);
        return v / 16384;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // scale, center, rotate x/y/z, optional iso projection, screen offset
    function automatic screen_t project_point(input point_t p);
        screen_t r;
        longint  zm;
        longint  x;
        longint  y;
        longint  z;
        longint  c;
        longint  s;
        longint  t0;
        longint  t1;
        int      a;
        zm = longint'(zoom_r);
        x = longint'(p.px) * zm - (longint'(map_w_r) * zm) / 8;
        y = longint'(p.py) * zm - (longint'(map_h_r) * zm) / 8;
        z = longint'(p.pz) * longint'(z_zoom_r);
        for (int ax = 0; ax < 3; ax++)
        begin
            a = int'((angles_r >> (ax * AB)) & (ANG_N - 1));
            s = sine_lut[a];
            c = sine_lut[(a + ANG_N / 4) % ANG_N];
            if (ax == 0)
            begin
                t0 = q14(y * c + z * s);
                t1 = q14(-y * s + z * c);
                y = t0;
                z = t1;
            end
            else if (ax == 1)
            begin
                t0 = q14(x * c + z * s);
                t1 = q14(-x * s + z * c);
                x = t0;
                z = t1;
            end
            else
            begin
                t0 = q14(x * c - y * s);
                t1 = q14(x * s + y * c);
                x = t0;
                y = t1;
            end
        end
        if (iso_r)
        begin
            t0 = q14((x - y) * 11415);
            t1 = q14((x + y) * 11753) - z;
            x = t0;
            y = t1;
        end
        x = x + SCREEN_WIDTH_DEF / 8 + longint'(shift_x_r);
        y = y + (SCREEN_HEIGHT_DEF + longint'(map_h_r) * zm) / 8 + longint'(shift_y_r);
        r.sx = clamp32(x);
        r.sy = clamp32(y);
        r.dz = clamp32(z);
        return r;
    endfunction

    // drive the point word; take the next one unless idling
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            point_x <= '0;
            point_y <= '0;
            point_z <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                point_t acc_p;
                acc_p.px = point_x;
                acc_p.py = point_y;
                acc_p.pz = point_z;
                expected_screen.push_back(project_point(acc_p));
                n_points++;
            end
            if ((!start || !busy) )
            begin
                if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    point_t np;
                    np = pending_points.pop_front();
                    start   <= 1'b1;
                    point_x <= np.px;
                    point_y <= np.py;
                    point_z <= np.pz;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // check each result word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_screen.size() == 0)
            begin
                $error("result with no point pending: %0d %0d %0d", screen_x, screen_y, depth_z);
                n_errors++;
            end
            else
            begin
                screen_t e;
                e = expected_screen.pop_front();
                if (screen_x !== e.sx)
                begin
                    $error("screen_x expected %0d got %0d", e.sx, screen_x);
                    n_errors++;
                end
                if (screen_y !== e.sy)
                begin
                    $error("screen_y expected %0d got %0d", e.sy, screen_y);
                    n_errors++;
                end
                if (depth_z !== e.dz)
                begin
                    $error("depth_z expected %0d got %0d", e.dz, depth_z);
                    n_errors++;
                end
            end
            n_results++;
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("watchdog expired");
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [29:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        case (idx)
            REG_ZOOM:       zoom_r    = val[7:0];
            REG_Z_ZOOM:     z_zoom_r  = val[13:0];
            REG_ANGLES:     angles_r  = val;
            REG_ISO_MODE:   iso_r     = val[0];
            REG_MAP_WIDTH:  map_w_r   = val[12:0];
            REG_MAP_HEIGHT: map_h_r   = val[12:0];
            REG_SHIFT_X:    shift_x_r = val[15:0];
            default:        shift_y_r = val[15:0];
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // hold until every point has gone through and the pipe is empty
    task automatic drain();
        while (pending_points.size() > 0 || start || expected_screen.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic add_point(input logic [11:0] x, input logic [11:0] y,
                             input logic [15:0] z);
        point_t p;
        p.px = x;
        p.py = y;
        p.pz = z;
        pending_points.push_back(p);
    endtask

    task automatic add_random_points(input int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(7))
                0:       add_point($urandom_range(1) ? 12'hFFF : 12'h000,
                                   $urandom_range(1) ? 12'hFFF : 12'h000,
                                   $urandom_range(1) ? 16'h8000 : 16'h7FFF);
                1:       add_point(12'($urandom_range(63)), 12'($urandom_range(63)),
                                   16'($urandom_range(255) - 128));
                default: add_point(12'($urandom), 12'($urandom), 16'($urandom));
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        n_points = 0;
        n_results = 0;
        n_errors = 0;
        quiet_cycles = 0;
        zoom_r = 8'd20;
        z_zoom_r = 14'sd20;
        angles_r = '0;
        iso_r = 1'b1;
        map_w_r = '0;
        map_h_r = '0;
        shift_x_r = '0;
        shift_y_r = '0;
        // build the full-turn table from the mirrored quarter wave
        for (int a = 0; a < ANG_N; a++)
        begin
            int q;
            int r;
            int v;
            q = (a >> (AB - 2)) & 3;
            r = a & (ANG_N / 4 - 1);
            v = (q & 1) ? quarter_wave(ANG_N / 4 - r) : quarter_wave(r);
            sine_lut[a] = (q & 2) ? -v : v;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // field extremes at reset defaults
        add_point(12'h000, 12'h000, 16'h0000);
        add_point(12'hFFF, 12'hFFF, 16'h7FFF);
        add_point(12'hFFF, 12'h000, 16'h8000);
        add_point(12'h000, 12'hFFF, 16'hFFFF);
        add_point(12'hAAA, 12'h555, 16'h5555);
        add_point(12'h555, 12'hAAA, 16'hAAAA);
        drain();

        // extreme settings: max scale, min scales, saturation, parallel view
        write_reg(REG_ZOOM, 30'd255);
        write_reg(REG_Z_ZOOM, 30'h3FFF & 14'h2000);
        write_reg(REG_ANGLES, 30'h3FFF_FFFF);
        write_reg(REG_ISO_MODE, 30'd0);
        write_reg(REG_MAP_WIDTH, 30'h1FFF);
        write_reg(REG_MAP_HEIGHT, 30'h1FFF);
        write_reg(REG_SHIFT_X, 30'h7FFF);
        write_reg(REG_SHIFT_Y, 30'h8000);
        add_point(12'hFFF, 12'hFFF, 16'h8000);
        add_point(12'h000, 12'h000, 16'h7FFF);
        add_point(12'hFFF, 12'h000, 16'h7FFF);
        drain();
        write_reg(REG_ZOOM, 30'd0);
        write_reg(REG_Z_ZOOM, 30'h1FFF);
        write_reg(REG_ISO_MODE, 30'd1);
        write_reg(REG_SHIFT_X, 30'h8000);
        write_reg(REG_SHIFT_Y, 30'h7FFF);
        add_point(12'hFFF, 12'hFFF, 16'h7FFF);
        add_point(12'h000, 12'h000, 16'h8000);
        drain();

        // random settings, cycling through three idling patterns
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_ZOOM, $urandom_range(3) == 0 ? 30'd1 : 30'($urandom_range(255)));
            write_reg(REG_Z_ZOOM, 30'($urandom));
            write_reg(REG_ANGLES, ph == 0 ? 30'd0 : 30'($urandom));
            write_reg(REG_ISO_MODE, 30'(ph % 2));
            write_reg(REG_MAP_WIDTH, $urandom_range(1) ? 30'($urandom_range(4096)) : 30'($urandom));
            write_reg(REG_MAP_HEIGHT, $urandom_range(1) ? 30'($urandom_range(4096)) : 30'($urandom));
            write_reg(REG_SHIFT_X, 30'($urandom));
            write_reg(REG_SHIFT_Y, 30'($urandom));
            case (ph % 3)
                0:       send_idle_pct = 0;
                1:       send_idle_pct = 65;
                default: send_idle_pct = 27;
            endcase
            add_random_points(155);
            drain();
        end

        $display("covered %0d points and %0d results over 11 register settings,",
                 n_points, n_results);
        $display("with sender idling at 0, 27 and 65 percent");
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire

// File: point_3d_projection_top.f
src/p3dp_pkg.sv
src/point_3d_projection_top.sv
tb/tb_point_3d_projection_top.sv
